// ----- rtl/core/alps_pkg.sv -----
// ----------------------------------------------------------------------------
// alps_pkg
// Shared constants, types and helpers of the LED pixel serializer.
// ----------------------------------------------------------------------------
package alps_pkg;

  // Chain geometry.
  localparam int LED_COUNT    = 16;
  localparam int BITS_PER_LED = 24;
  localparam int PIXEL_SLOTS  = LED_COUNT * BITS_PER_LED;
  localparam int ADDR_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int PCNT_W       = $clog2(LED_COUNT + 1);
  localparam int BIT_W        = $clog2(BITS_PER_LED);
  localparam int SLOT_W       = $clog2(PIXEL_SLOTS + 1024);

  // Field widths.
  localparam int DUTY_W  = 16;
  localparam int TRAIL_W = 10;
  localparam int LEVEL_W = 8;
  localparam int BRIGHT_W = 4;
  localparam int PIXEL_W = 3 * LEVEL_W;

  // Special index that addresses every pixel.
  localparam logic [7:0] ALL_LEDS = 8'hFF;

  // Item kinds.
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register map (word index), APB bus shape.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_ONE_DUTY  = 2'd0;
  localparam logic [1:0] REG_ZERO_DUTY = 2'd1;
  localparam logic [1:0] REG_TRAILING  = 2'd2;

  // Register reset values.
  localparam logic [DUTY_W-1:0]  ONE_DUTY_RST  = 16'd67;
  localparam logic [DUTY_W-1:0]  ZERO_DUTY_RST = 16'd33;
  localparam logic [TRAIL_W-1:0] TRAILING_RST  = 10'd64;

  // Configuration values seen by the sequencer.
  typedef struct packed {
    logic [DUTY_W-1:0]  one_bit_duty;
    logic [DUTY_W-1:0]  zero_bit_duty;
    logic [TRAIL_W-1:0] trailing_words;
  } cfg_t;

  // Access request to the pixel store.
  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } mem_req_t;

  // Registered read data of the pixel store.
  typedef struct packed {
    logic [PIXEL_W-1:0] data;
    logic               written;
  } mem_rsp_t;

  // Scale one color level: ((c + 1) >> 4) * tenths, kept to 8 bits.
  function automatic logic [LEVEL_W-1:0] scale_level(
    input logic [LEVEL_W-1:0]  c,
    input logic [BRIGHT_W-1:0] tenths
  );
    logic [LEVEL_W:0] inc;
    logic [4:0]       coarse;
    logic [8:0]       prod;
    inc    = {1'b0, c} + 9'd1;
    coarse = inc[8:4];
    prod   = 9'(coarse) * 9'(tenths);
    return prod[LEVEL_W-1:0];
  endfunction

endpackage

// ----- rtl/core/alps_if.sv -----
// ----------------------------------------------------------------------------
// alps_in_if / alps_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface alps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] brightness;

  modport source (output valid, kind, led_index, red, green, blue, brightness,
                  input ready);
  modport sink   (input valid, kind, led_index, red, green, blue, brightness,
                  output ready);
endinterface

interface alps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        in_frame;
  logic        frame_end;

  modport source (output valid, duty, in_frame, frame_end, input ready);
  modport sink   (input valid, duty, in_frame, frame_end, output ready);
endinterface

// ----- rtl/core/alps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// alps_cfg_regs
// APB register file holding the two bit duties and the trailing gap length.
// ----------------------------------------------------------------------------
module alps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [alps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [alps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [alps_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output alps_pkg::cfg_t                 cfg
);
  import alps_pkg::*;

  logic       wr_access;
  logic [1:0] reg_idx;

  assign pready    = 1'b1;
  assign wr_access = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_bit_duty   <= ONE_DUTY_RST;
      cfg.zero_bit_duty  <= ZERO_DUTY_RST;
      cfg.trailing_words <= TRAILING_RST;
    end else if (wr_access) begin
      case (reg_idx)
        REG_ONE_DUTY:  cfg.one_bit_duty   <= pwdata[DUTY_W-1:0];
        REG_ZERO_DUTY: cfg.zero_bit_duty  <= pwdata[DUTY_W-1:0];
        REG_TRAILING:  cfg.trailing_words <= pwdata[TRAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_ONE_DUTY:  prdata = {{(APB_DATA_W-DUTY_W){1'b0}}, cfg.one_bit_duty};
      REG_ZERO_DUTY: prdata = {{(APB_DATA_W-DUTY_W){1'b0}}, cfg.zero_bit_duty};
      REG_TRAILING:  prdata = {{(APB_DATA_W-TRAIL_W){1'b0}}, cfg.trailing_words};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/alps_pixel_store.sv -----
// ----------------------------------------------------------------------------
// alps_pixel_store
// GRB pixel memory, one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module alps_pixel_store (
  input  logic               clk,
  input  logic               rst,
  input  alps_pkg::mem_req_t req,
  output alps_pkg::mem_rsp_t rsp
);
  import alps_pkg::*;

  logic [PIXEL_W-1:0] mem [LED_COUNT];
  logic [LED_COUNT-1:0] written;

  // Pixel data array and written flags: a pixel never written reads as dark.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rsp.data <= mem[req.rd_addr];
    end
    if (rst) begin
      written     <= '0;
      rsp.written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rsp.written <= written[req.rd_addr];
      end
    end
  end

endmodule

// ----- rtl/core/alps_frame_seq.sv -----
// ----------------------------------------------------------------------------
// alps_frame_seq
// Item sequencer: pixel writes and fills, frame slot counting, result word.
// ----------------------------------------------------------------------------
module alps_frame_seq (
  input  logic               clk,
  input  logic               rst,
  alps_in_if.sink            in_ch,
  alps_out_if.source         out_ch,
  input  alps_pkg::cfg_t     cfg,
  output alps_pkg::mem_req_t req,
  input  alps_pkg::mem_rsp_t rsp
);
  import alps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  // Frame state.
  logic              pending;
  logic              sending;
  logic [SLOT_W-1:0] slot;
  logic [PCNT_W-1:0] pix;
  logic [BIT_W-1:0]  bitc;

  // Pending write.
  logic [PIXEL_W-1:0] word;
  logic [ADDR_W-1:0]  fill_addr;
  logic               fill_all;

  // Tick captured for the output stage.
  logic             t_active;
  logic             t_pixel;
  logic             t_end;
  logic [BIT_W-1:0] t_bit;

  // Output register.
  logic              out_valid;
  logic [DUTY_W-1:0] out_duty;
  logic              out_frame;
  logic              out_end;

  logic               accept;
  logic               acc_set;
  logic               acc_tick;
  logic               start;
  logic               send_eff;
  logic [SLOT_W-1:0]  slot_eff;
  logic [PCNT_W-1:0]  pix_eff;
  logic [BIT_W-1:0]   bit_eff;
  logic               in_pixels;
  logic [SLOT_W-1:0]  last_slot;
  logic               end_now;
  logic [PIXEL_W-1:0] set_word;
  logic               idx_ok;
  logic               fill_done;
  logic               load_out;
  logic [BIT_W-1:0]   sel;
  logic               bit_val;
  logic [DUTY_W-1:0]  duty_calc;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign acc_set     = accept && (in_ch.kind == KIND_SET);
  assign acc_tick    = accept && (in_ch.kind == KIND_TICK);

  // Scaled GRB word of a set-color item.
  assign set_word = {scale_level(in_ch.green, in_ch.brightness),
                     scale_level(in_ch.red,   in_ch.brightness),
                     scale_level(in_ch.blue,  in_ch.brightness)};
  assign idx_ok   = (in_ch.led_index < 8'(LED_COUNT));

  // A tick starts a pending frame and already sends its first slot.
  assign start     = !sending && pending;
  assign send_eff  = sending || pending;
  assign slot_eff  = start ? '0 : slot;
  assign pix_eff   = start ? '0 : pix;
  assign bit_eff   = start ? '0 : bitc;
  assign in_pixels = (pix_eff < PCNT_W'(LED_COUNT));
  assign last_slot = SLOT_W'(PIXEL_SLOTS) + SLOT_W'(cfg.trailing_words) - SLOT_W'(1);
  assign end_now   = (slot_eff >= last_slot);

  assign fill_done = !fill_all || (fill_addr == ADDR_W'(LED_COUNT - 1));
  assign load_out  = (state == S_OUT) && (!out_valid || out_ch.ready);

  // Pixel store requests: fill writes and the live read of a tick.
  always_comb begin
    req.wr_en   = (state == S_FILL);
    req.wr_addr = fill_addr;
    req.wr_data = word;
    req.rd_en   = acc_tick && send_eff && in_pixels;
    req.rd_addr = pix_eff[ADDR_W-1:0];
  end

  // Sequencer state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_tick) begin
          state_next = S_OUT;
        end else if (acc_set && ((in_ch.led_index == ALL_LEDS) || idx_ok)) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame counters and pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      sending <= 1'b0;
      slot    <= '0;
      pix     <= '0;
      bitc    <= '0;
    end else if (acc_set) begin
      pending <= 1'b1;
    end else if (acc_tick && send_eff) begin
      if (start) begin
        pending <= 1'b0;
      end
      if (end_now) begin
        sending <= 1'b0;
        slot    <= '0;
        pix     <= '0;
        bitc    <= '0;
      end else begin
        sending <= 1'b1;
        slot    <= slot_eff + SLOT_W'(1);
        if (bit_eff == BIT_W'(BITS_PER_LED - 1)) begin
          bitc <= '0;
          if (in_pixels) begin
            pix <= pix_eff + PCNT_W'(1);
          end else begin
            pix <= pix_eff;
          end
        end else begin
          bitc <= bit_eff + BIT_W'(1);
          pix  <= pix_eff;
        end
      end
    end
  end

  // Write request and fill address.
  always_ff @(posedge clk) begin
    if (acc_set) begin
      word      <= set_word;
      fill_all  <= (in_ch.led_index == ALL_LEDS);
      fill_addr <= (in_ch.led_index == ALL_LEDS) ? '0 : in_ch.led_index[ADDR_W-1:0];
    end else if ((state == S_FILL) && !fill_done) begin
      fill_addr <= fill_addr + ADDR_W'(1);
    end
  end

  // Tick details kept until the read data is back.
  always_ff @(posedge clk) begin
    if (acc_tick) begin
      t_active <= send_eff;
      t_pixel  <= send_eff && in_pixels;
      t_end    <= send_eff && end_now;
      t_bit    <= bit_eff;
    end
  end

  // Bit select, MSB first within the GRB word.
  assign sel       = BIT_W'(BITS_PER_LED - 1) - t_bit;
  assign bit_val   = rsp.written && rsp.data[sel];
  assign duty_calc = !t_pixel ? '0 : (bit_val ? cfg.one_bit_duty : cfg.zero_bit_duty);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_duty  <= duty_calc;
      out_frame <= t_active;
      out_end   <= t_end;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.duty      = out_duty;
  assign out_ch.in_frame  = out_frame;
  assign out_ch.frame_end = out_end;

  // The last word of a frame is always a frame word.
  a_end_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_frame)
    else $error("frame_end without in_frame");

  // Fill writes and tick reads never share a cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en))
    else $error("pixel store read and write in one cycle");

  // Fill address stays inside the chain.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> fill_addr <= ADDR_W'(LED_COUNT - 1))
    else $error("fill address out of range");

  // A frame slot that does not end the frame advances the slot count by one.
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    acc_tick && send_eff && !end_now |=> slot == $past(slot_eff) + SLOT_W'(1))
    else $error("slot count did not advance");

endmodule

// ----- rtl/core/addressable_led_pixel_serializer_top.sv -----
// ----------------------------------------------------------------------------
// addressable_led_pixel_serializer_top
// Pixel store and bit-slot serializer for a chain of addressable RGB LEDs.
// ----------------------------------------------------------------------------
// One word is taken at a time. A tick word reads the pixel memory through a
// registered read, and its result word is loaded into the output register
// once that register is free; a new word is accepted as soon as that result
// sits in the output register. A set-color word for one pixel writes one
// memory entry, one with an out-of-range index writes none, and a broadcast
// (index 255) fills all LED_COUNT entries, writing one entry per cycle.
// Registers: one_bit_duty at 0x0, zero_bit_duty at 0x4, trailing_words at 0x8.
// ----------------------------------------------------------------------------
module addressable_led_pixel_serializer_top (
  input  logic                           clk,
  input  logic                           rst,
  alps_in_if.sink                        in_ch,
  alps_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [alps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [alps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [alps_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import alps_pkg::*;

  cfg_t     cfg;
  mem_req_t req;
  mem_rsp_t rsp;

  // Configuration registers.
  alps_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pixel memory.
  alps_pixel_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Sequencer and output stage.
  alps_frame_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .req    (req),
    .rsp    (rsp)
  );

endmodule
